>>> hdl/med3x3_pkg.sv
// ----------------------------------------------------------------------------
// med3x3_pkg
// Shared types, constants and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package med3x3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW        = $clog2(MAX_WIDTH + 1);
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int ROW_W     = FH_W + 1;
    localparam int CMP_W     = (EW > FW_W) ? EW : FW_W;
    localparam int PIX_W     = 8;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // one window column, sorted ascending
    typedef struct packed
    {
        pix_t mx;
        pix_t md;
        pix_t mn;
    } col_t;

    typedef struct packed
    {
        pix_t             val;
        logic [COL_W-1:0] col;
        logic             top_zero;
        logic             emit;
        logic             first_col;
        logic             last_col;
        logic             frame_end;
    } s1_t;

    typedef struct packed
    {
        logic first_col;
        logic last_col;
        logic frame_end;
    } s2_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col_t r;
        r.mn = min3(a, b, c);
        r.md = med3(a, b, c);
        r.mx = max3(a, b, c);
        return r;
    endfunction

endpackage

>>> hdl/med3x3_pix_if.sv
// ----------------------------------------------------------------------------
// med3x3_pix_if
// Pixel input channel: valid/ready handshake with action and pixel payload.
// ----------------------------------------------------------------------------
interface med3x3_pix_if;

    logic              valid;
    logic              ready;
    logic              action;
    med3x3_pkg::pix_t  pixel;

    modport source
    (
        output valid,
        output action,
        output pixel,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  pixel,
        output ready
    );

endinterface

>>> hdl/med3x3_res_if.sv
// ----------------------------------------------------------------------------
// med3x3_res_if
// Result channel: valid/ready handshake with median and row/frame markers.
// ----------------------------------------------------------------------------
interface med3x3_res_if;

    logic              valid;
    logic              ready;
    med3x3_pkg::pix_t  median_value;
    logic              row_end;
    logic              frame_end;

    modport source
    (
        output valid,
        output median_value,
        output row_end,
        output frame_end,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  median_value,
        input  row_end,
        input  frame_end,
        output ready
    );

endinterface

>>> hdl/median_3x3_zero_pad_top.sv
// ----------------------------------------------------------------------------
// median_3x3_zero_pad_top
// Path: a window's result passes the stage 1, window/stage 2 and output
// registers, one row plus one pixel behind its pixel. Throughput: one word
// per cycle unless results stall, set by the single-port-pair line store.
// Reset: frame counters and window clear, size returns to 640 x 480;
// line store contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module median_3x3_zero_pad_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [med3x3_pkg::PADDR_W-1:0]     paddr,
    input  logic [med3x3_pkg::PDATA_W-1:0]     pwdata,
    output logic [med3x3_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    med3x3_pix_if.sink                         pixels,
    med3x3_res_if.source                       results
);

    logic [med3x3_pkg::FW_W-1:0]   frame_width_reg;
    logic [med3x3_pkg::FH_W-1:0]   frame_height_reg;
    logic                          cfg_wr;
    med3x3_pkg::reg_idx_t          reg_idx;

    logic [med3x3_pkg::CMP_W-1:0]  fw_ext;
    logic [med3x3_pkg::COL_W-1:0]  w_last;
    logic [med3x3_pkg::FH_W-1:0]   h_eff;
    logic [med3x3_pkg::FH_W-1:0]   h_last;
    logic [med3x3_pkg::ROW_W-1:0]  h_eff_ext;

    logic [med3x3_pkg::COL_W-1:0]  in_col_reg;
    logic [med3x3_pkg::COL_W-1:0]  in_col_next;
    logic [med3x3_pkg::ROW_W-1:0]  in_row_reg;
    logic [med3x3_pkg::ROW_W-1:0]  in_row_next;
    logic [med3x3_pkg::COL_W-1:0]  out_col_reg;
    logic [med3x3_pkg::COL_W-1:0]  out_col_next;
    logic [med3x3_pkg::FH_W-1:0]   out_row_reg;
    logic [med3x3_pkg::FH_W-1:0]   out_row_next;

    logic                          in_frame;
    logic                          in_acc;
    logic                          take;
    logic                          emit;
    logic                          row_end;
    logic                          frame_end;

    med3x3_pkg::s1_t               s1_reg;
    med3x3_pkg::s1_t               s1_next;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_adv;

    med3x3_pkg::s2_t               s2_reg;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic                          s2_adv;

    logic                          ram_re;
    logic                          ram_we;
    logic [med3x3_pkg::COL_W-1:0]  ram_raddr;
    logic [med3x3_pkg::COL_W-1:0]  ram_waddr;
    logic [med3x3_pkg::LINE_W-1:0] ram_wdata;
    logic [med3x3_pkg::LINE_W-1:0] ram_rdata;

    med3x3_pkg::pix_t              up_m;
    med3x3_pkg::pix_t              lo_p;
    med3x3_pkg::col_t              new_col;
    med3x3_pkg::col_t              win_reg [3];

    med3x3_pkg::col_t              c0;
    med3x3_pkg::col_t              c1;
    med3x3_pkg::col_t              c2;
    med3x3_pkg::pix_t              max_of_mins;
    med3x3_pkg::pix_t              med_of_meds;
    med3x3_pkg::pix_t              min_of_maxes;
    med3x3_pkg::pix_t              median_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    med3x3_pkg::pix_t              median_reg;
    logic                          row_end_reg;
    logic                          frame_end_reg;

    // configuration port
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = med3x3_pkg::reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= med3x3_pkg::FW_RESET;
            frame_height_reg <= med3x3_pkg::FH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                med3x3_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= pwdata[med3x3_pkg::FW_W-1:0];
                end
                med3x3_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= pwdata[med3x3_pkg::FH_W-1:0];
                end
                default:
                begin
                    frame_width_reg <= frame_width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            med3x3_pkg::REG_FRAME_WIDTH:  prdata = med3x3_pkg::PDATA_W'(frame_width_reg);
            med3x3_pkg::REG_FRAME_HEIGHT: prdata = med3x3_pkg::PDATA_W'(frame_height_reg);
            default:                      prdata = '0;
        endcase
    end

    // effective frame size
    assign fw_ext = med3x3_pkg::CMP_W'(frame_width_reg);

    always_comb
    begin
        priority if (fw_ext > med3x3_pkg::CMP_W'(med3x3_pkg::MAX_WIDTH))
        begin
            w_last = med3x3_pkg::COL_W'(med3x3_pkg::MAX_WIDTH - 1);
        end
        else if (fw_ext < med3x3_pkg::CMP_W'(3))
        begin
            w_last = med3x3_pkg::COL_W'(2);
        end
        else
        begin
            w_last = med3x3_pkg::COL_W'(fw_ext - med3x3_pkg::CMP_W'(1));
        end
    end

    assign h_eff     = (frame_height_reg == '0) ? med3x3_pkg::FH_W'(1) : frame_height_reg;
    assign h_last    = h_eff - med3x3_pkg::FH_W'(1);
    assign h_eff_ext = med3x3_pkg::ROW_W'(h_eff);

    // input and output side position tracking
    assign in_frame  = in_row_reg < h_eff_ext;
    assign in_acc    = pixels.valid && pixels.ready;
    assign take      = in_acc && !(pixels.action && in_frame);
    assign emit      = (in_row_reg >= med3x3_pkg::ROW_W'(2))
                       || ((in_row_reg == med3x3_pkg::ROW_W'(1)) && (in_col_reg != '0));
    assign row_end   = out_col_reg == w_last;
    assign frame_end = row_end && (out_row_reg == h_last);

    assign pixels.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        priority if (cfg_wr || (take && emit && frame_end))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (in_col_reg == w_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + med3x3_pkg::ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + med3x3_pkg::COL_W'(1);
            end
            if (emit)
            begin
                if (row_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + med3x3_pkg::FH_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + med3x3_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // stage 1: word register, line store read in flight
    always_comb
    begin
        s1_next.val       = in_frame ? pixels.pixel : '0;
        s1_next.col       = in_col_reg;
        s1_next.top_zero  = in_row_reg == med3x3_pkg::ROW_W'(1);
        s1_next.emit      = emit;
        s1_next.first_col = out_col_reg == '0;
        s1_next.last_col  = row_end;
        s1_next.frame_end = frame_end;
    end

    assign s1_valid_next = take || (s1_valid_reg && !s1_adv);
    assign s1_adv        = s1_valid_reg && (!s2_valid_reg || s2_adv);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= s1_next;
        end
    end

    // line store: upper row in high byte, lower row in low byte
    assign ram_re    = take;
    assign ram_raddr = in_col_reg;
    assign ram_we    = s1_adv;
    assign ram_waddr = s1_reg.col;
    assign ram_wdata = {ram_rdata[med3x3_pkg::PIX_W-1:0], s1_reg.val};

    med3x3_ram #(
        .WIDTH (med3x3_pkg::LINE_W),
        .DEPTH (med3x3_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // new column, top row masked on the first output row, then sorted
    assign up_m    = s1_reg.top_zero ? '0 : ram_rdata[med3x3_pkg::LINE_W-1:med3x3_pkg::PIX_W];
    assign lo_p    = ram_rdata[med3x3_pkg::PIX_W-1:0];
    assign new_col = med3x3_pkg::sort3(up_m, lo_p, s1_reg.val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= new_col;
        end
    end

    // stage 2: window holds the neighborhood of this word's output pixel
    assign s2_valid_next = (s1_adv && s1_reg.emit) || (s2_valid_reg && !s2_adv);
    assign s2_adv        = s2_valid_reg && (!out_valid_reg || results.ready);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_reg.first_col <= s1_reg.first_col;
            s2_reg.last_col  <= s1_reg.last_col;
            s2_reg.frame_end <= s1_reg.frame_end;
        end
    end

    // median of nine from three sorted columns
    assign c0 = s2_reg.first_col ? '0 : win_reg[0];
    assign c1 = win_reg[1];
    assign c2 = s2_reg.last_col ? '0 : win_reg[2];

    assign max_of_mins  = med3x3_pkg::max3(c0.mn, c1.mn, c2.mn);
    assign med_of_meds  = med3x3_pkg::med3(c0.md, c1.md, c2.md);
    assign min_of_maxes = med3x3_pkg::min3(c0.mx, c1.mx, c2.mx);
    assign median_next  = med3x3_pkg::med3(max_of_mins, med_of_meds, min_of_maxes);

    // output register
    assign out_valid_next = s2_adv || (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            median_reg    <= median_next;
            row_end_reg   <= s2_reg.last_col;
            frame_end_reg <= s2_reg.frame_end;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.median_value = median_reg;
    assign results.row_end      = row_end_reg;
    assign results.frame_end    = frame_end_reg;

    // checks
    a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re && (in_row_reg != '0) |-> ram_waddr != ram_raddr)
        else $error("line store read and write hit the same entry");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= h_eff_ext + med3x3_pkg::ROW_W'(1))
        else $error("input row ran past the drain");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg <= w_last) && (out_col_reg <= w_last))
        else $error("column counter beyond frame width");

endmodule

>>> hdl/med3x3_ram.sv
// ----------------------------------------------------------------------------
// med3x3_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module med3x3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams grayscale frames through the 3x3 zero-padded median filter and
// checks every median word against a cycle-free model of the filter. A short
// table covers reset, register saturation and the drain corner cases, then
// random frames of small sizes and one tall partial frame under a long
// result stall follow, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    localparam int   RANDOM_WORDS = 820;
    localparam int   DRAIN_LIMIT  = 100000;

    typedef enum logic [1:0]
    {
        ROW_WIDTH,
        ROW_HEIGHT,
        ROW_PIXEL,
        ROW_FLUSH
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t         kind;
        logic [11:0]       value;
        logic              typed;
        med3x3_pkg::pix_t  med;
        logic              re;
        logic              fe;
    } row_t;

    typedef struct packed
    {
        med3x3_pkg::pix_t med;
        logic             row_end;
        logic             frame_end;
    } median_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [med3x3_pkg::PADDR_W-1:0]  paddr;
    logic [med3x3_pkg::PDATA_W-1:0]  pwdata;
    logic [med3x3_pkg::PDATA_W-1:0]  prdata;
    logic                            pready;

    med3x3_pix_if pix_ch();
    med3x3_res_if res_ch();

    median_3x3_zero_pad_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixels  (pix_ch),
        .results (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter model state
    logic [med3x3_pkg::FW_W-1:0]  cfg_width;
    logic [med3x3_pkg::FH_W-1:0]  cfg_height;
    med3x3_pkg::pix_t             held_top [med3x3_pkg::MAX_WIDTH];
    med3x3_pkg::pix_t             held_mid [med3x3_pkg::MAX_WIDTH];
    logic [23:0]                  win_cols [3];
    logic [10:0]                  next_col;
    logic [med3x3_pkg::ROW_W-1:0] next_row;
    logic [21:0]                  medians_out;

    median_word_t medians_due [$];

    int  mismatches   = 0;
    int  frame_words  = 0;
    int  words_sent   = 0;
    int  regs_written = 0;
    int  medians_seen = 0;
    int  frames_done  = 0;
    bit  sender_steady = 1'b0;
    bit  stall_req     = 1'b0;

    row_t steps [24] = '{
        '{ROW_FLUSH,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_WIDTH,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_HEIGHT, 12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'h0a5,  1'b1, 8'd0,   1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd0,   1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd0,   1'b1, 1'b1},
        '{ROW_FLUSH,  12'd0,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_WIDTH,  12'd3,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_HEIGHT, 12'd2,    1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b0, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b1, 8'd0,   1'b0, 1'b0},
        '{ROW_PIXEL,  12'd255,  1'b1, 8'd255, 1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd0,   1'b1, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd0,   1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd255, 1'b0, 1'b0},
        '{ROW_FLUSH,  12'd0,    1'b1, 8'd0,   1'b1, 1'b1}
    };

    function automatic int unsigned eff_width();
        if (cfg_width < 3)
            return 3;
        if (cfg_width > med3x3_pkg::MAX_WIDTH)
            return med3x3_pkg::MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(12, 30);
    endfunction

    // advances the model by one accepted word, returns 1 when a median leaves
    function automatic bit filter_pixel(input logic act, input med3x3_pkg::pix_t px,
                                        output median_word_t word);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ic;
        int unsigned      val;
        int unsigned      orow;
        int unsigned      ocol;
        int unsigned      total;
        logic [23:0]      cols [3];
        med3x3_pkg::pix_t nb [9];
        med3x3_pkg::pix_t v;
        bit               in_frame;
        bit               emit;
        int               k;
        int               rr;
        int               j;
        word = '0;
        w = eff_width();
        h = eff_height();
        in_frame = next_row < h;
        if (act == ACT_FLUSH && in_frame)
            return 1'b0;
        if (next_col >= w)
            next_col = '0;
        val = in_frame ? int'(px) : 0;
        ic = next_col;
        emit = (next_row >= 2) || (next_row == 1 && ic >= 1);
        if (ic == 0)
        begin
            cols[0] = win_cols[1];
            cols[1] = win_cols[2];
            cols[2] = '0;
        end
        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = {held_top[ic], held_mid[ic], med3x3_pkg::pix_t'(val)};
        held_top[ic] = held_mid[ic];
        held_mid[ic] = med3x3_pkg::pix_t'(val);
        if (ic != 0)
            cols = win_cols;
        if (ic + 1 >= w)
        begin
            next_col = '0;
            next_row = next_row + 1'b1;
        end
        else
            next_col = 11'(ic + 1);
        if (!emit)
            return 1'b0;

        total = w * h;
        orow = medians_out / w;
        ocol = medians_out % w;
        if (ocol == 0)
            cols[0] = '0;
        if (ocol == w - 1)
            cols[2] = '0;
        for (k = 0; k < 3; k++)
            for (rr = 0; rr < 3; rr++)
            begin
                v = cols[k][16 - 8 * rr +: 8];
                if ((rr == 0 && orow == 0) || (rr == 2 && orow == h - 1))
                    v = '0;
                nb[k * 3 + rr] = v;
            end
        for (k = 1; k < 9; k++)
        begin
            v = nb[k];
            j = k - 1;
            while (j >= 0 && nb[j] > v)
            begin
                nb[j + 1] = nb[j];
                j--;
            end
            nb[j + 1] = v;
        end
        word.med = nb[4];
        word.row_end = (ocol == w - 1);
        word.frame_end = (medians_out + 1 >= total);
        medians_out = medians_out + 1'b1;
        if (medians_out >= total)
        begin
            next_col = '0;
            next_row = '0;
            medians_out = '0;
        end
        return 1'b1;
    endfunction

    // stop offering words and wait until every median is back
    task automatic settle();
        int waited;
        waited = 0;
        pix_ch.valid <= 1'b0;
        while (medians_due.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (medians_due.size() > 0)
        begin
            $display("%0t: expected %0d more medians, actual none arrived", $time,
                     medians_due.size());
            mismatches++;
            medians_due.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input med3x3_pkg::reg_idx_t idx,
                             input logic [med3x3_pkg::PDATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= med3x3_pkg::PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == med3x3_pkg::REG_FRAME_WIDTH)
            cfg_width = value[med3x3_pkg::FW_W-1:0];
        else
            cfg_height = value[med3x3_pkg::FH_W-1:0];
        next_col = '0;
        next_row = '0;
        medians_out = '0;
        regs_written++;
        @(posedge clk);
    endtask

    task automatic send_word(input logic act, input med3x3_pkg::pix_t px, input bit typed,
                             input median_word_t typed_word);
        median_word_t word;
        int gap;
        pix_ch.valid  <= 1'b1;
        pix_ch.action <= act;
        pix_ch.pixel  <= px;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        words_sent++;
        if (filter_pixel(act, px, word))
            medians_due.push_back(typed ? typed_word : word);
        else if (typed)
        begin
            $display("%0t: table row expects a median, model gives none", $time);
            mismatches++;
        end
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // cut_at: -1 whole frame, -2 maybe cut at random or at the word budget,
    // else words before the cut
    task automatic drive_frame(input logic [med3x3_pkg::PDATA_W-1:0] wdata,
                               input logic [med3x3_pkg::PDATA_W-1:0] hdata,
                               input int cut_at, input int stall_at);
        int               total;
        int               pixels;
        int               stop;
        int               n;
        int               mode;
        int               base;
        med3x3_pkg::pix_t px;
        if ($urandom_range(0, 1))
        begin
            write_reg(med3x3_pkg::REG_FRAME_WIDTH, wdata);
            write_reg(med3x3_pkg::REG_FRAME_HEIGHT, hdata);
        end
        else
        begin
            write_reg(med3x3_pkg::REG_FRAME_HEIGHT, hdata);
            write_reg(med3x3_pkg::REG_FRAME_WIDTH, wdata);
        end
        pixels = eff_width() * eff_height();
        total = pixels + eff_width() + 1;
        stop = total;
        if (cut_at >= 0)
            stop = cut_at;
        else if (cut_at == -2 && $urandom_range(0, 9) == 0)
            stop = $urandom_range(1, total - 1);
        if (cut_at == -2 && stop > RANDOM_WORDS - frame_words)
            stop = RANDOM_WORDS - frame_words;
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        sender_steady = ($urandom_range(0, 3) == 0);
        for (n = 0; n < stop; n++)
        begin
            if (n == stall_at)
                stall_req = 1'b1;
            case (mode)
                0:       px = med3x3_pkg::pix_t'($urandom);
                1:       px = $urandom_range(0, 1) ? 8'hff : 8'h00;
                2:       px = med3x3_pkg::pix_t'(base ^ $urandom_range(0, 15));
                default: px = med3x3_pkg::pix_t'($urandom_range(0, 255));
            endcase
            if (n < pixels)
            begin
                // stray flush inside the frame is dropped
                if ($urandom_range(0, 19) == 0)
                    send_word(ACT_FLUSH, med3x3_pkg::pix_t'($urandom), 1'b0, '0);
                send_word(ACT_PIXEL, px, 1'b0, '0);
            end
            else if ($urandom_range(0, 6) == 0)
                send_word(ACT_PIXEL, px, 1'b0, '0);
            else
                send_word(ACT_FLUSH, px, 1'b0, '0);
            frame_words++;
        end
        if (stop == total)
            repeat ($urandom_range(0, 2))
                send_word(ACT_FLUSH, med3x3_pkg::pix_t'($urandom), 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int i;
        int roll;
        logic [med3x3_pkg::PDATA_W-1:0] wv;
        logic [med3x3_pkg::PDATA_W-1:0] hv;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.action = ACT_PIXEL;
        pix_ch.pixel = '0;
        cfg_width = med3x3_pkg::FW_RESET;
        cfg_height = med3x3_pkg::FH_RESET;
        for (i = 0; i < med3x3_pkg::MAX_WIDTH; i++)
        begin
            held_top[i] = '0;
            held_mid[i] = '0;
        end
        for (i = 0; i < 3; i++)
            win_cols[i] = '0;
        next_col = '0;
        next_row = '0;
        medians_out = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[i])
        begin
            case (steps[i].kind)
                ROW_WIDTH:
                    write_reg(med3x3_pkg::REG_FRAME_WIDTH,
                              med3x3_pkg::PDATA_W'(steps[i].value));
                ROW_HEIGHT:
                    write_reg(med3x3_pkg::REG_FRAME_HEIGHT,
                              med3x3_pkg::PDATA_W'(steps[i].value));
                default:
                    send_word(steps[i].kind == ROW_FLUSH ? ACT_FLUSH : ACT_PIXEL,
                              steps[i].value[7:0], steps[i].typed,
                              '{steps[i].med, steps[i].re, steps[i].fe});
            endcase
        end

        while (frame_words < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                wv = $urandom_range(3, 10);
            else if (roll < 85)
                wv = $urandom_range(11, 40);
            else if (roll < 93)
                wv = $urandom_range(0, 2);
            else
                wv = $urandom_range(41, 80);
            roll = $urandom_range(0, 99);
            if (roll < 55)
                hv = $urandom_range(1, 4);
            else if (roll < 85)
                hv = $urandom_range(5, 8);
            else if (roll < 93)
                hv = 0;
            else
                hv = $urandom_range(9, 12);
            // bits above the register field are don't care
            if ($urandom_range(0, 1))
                wv = wv | ($urandom & ~32'h7ff);
            if ($urandom_range(0, 1))
                hv = hv | ($urandom & ~32'hfff);
            drive_frame(wv, hv, -2, -1);
        end

        // tallest setting, left unfinished, with a long result stall
        drive_frame(32'd3, 32'd4095, 75, 20);
        settle();

        $display("checked %0d medians in %0d complete frames from %0d words",
                 medians_seen, frames_done, words_sent);
        $display("%0d register writes, widths 0 to 80, heights 0 to 4095, one long stall",
                 regs_written);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : result_sink
        median_word_t due;
        int hold;
        int idle;
        hold = 0;
        idle = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                medians_seen++;
                if (res_ch.frame_end)
                    frames_done++;
                if (medians_due.size() == 0)
                begin
                    $display("%0t: median word expected none actual %0d", $time,
                             res_ch.median_value);
                    mismatches++;
                end
                else
                begin
                    due = medians_due.pop_front();
                    if (res_ch.median_value !== due.med)
                    begin
                        $display("%0t: median_value expected %0d actual %0d", $time,
                                 due.med, res_ch.median_value);
                        mismatches++;
                    end
                    if (res_ch.row_end !== due.row_end)
                    begin
                        $display("%0t: row_end expected %0d actual %0d", $time,
                                 due.row_end, res_ch.row_end);
                        mismatches++;
                    end
                    if (res_ch.frame_end !== due.frame_end)
                    begin
                        $display("%0t: frame_end expected %0d actual %0d", $time,
                                 due.frame_end, res_ch.frame_end);
                        mismatches++;
                    end
                end
            end
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold = 600;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else if (idle > 0)
            begin
                idle--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                idle = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        #30_000_000;
        $display("timeout with %0d medians outstanding", medians_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> median_3x3_zero_pad_top.f
hdl/med3x3_pkg.sv
hdl/med3x3_pix_if.sv
hdl/med3x3_res_if.sv
hdl/med3x3_ram.sv
hdl/median_3x3_zero_pad_top.sv
sim/testbench.sv
